### rtl/okt_pkg.sv
// Package: payload structs, entry type, action and status codes, controller states.
`default_nettype none

package okt_pkg;

    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_SEARCH = 3'd2;
    localparam logic [2:0] ACT_MARK   = 3'd3;
    localparam logic [2:0] ACT_PEEK   = 3'd4;
    localparam logic [2:0] ACT_LIST   = 3'd5;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    localparam logic [1:0] PRIO_FIRST = 2'd1;
    localparam logic [1:0] PRIO_LAST  = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] task_id;
        logic [1:0]  task_priority;
    } okt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] entry_id;
        logic [1:0]  entry_priority;
        logic        entry_complete;
        logic [4:0]  entry_count;
        logic        last;
    } okt_out_t;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  prio;
        logic        complete;
    } okt_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_COUNT,
        ST_LIST,
        ST_PEEK,
        ST_RESP
    } okt_state_t;

endpackage

`default_nettype wire

### rtl/ordered_keyed_task_table.sv
// Ordered keyed task table: insertion-ordered entry memory with search, remove and list walks.
//
// Entries live in one single-port-read, single-port-write RAM (registered read) and are
// walked one entry per cycle by a read pipeline, except while a list beat waits on a
// stalled m_ output. One command is processed at a time; results go out through a registered
// m_ channel. Append writes directly; peek reads the last entry; search/mark scan to the match;
// remove scans to the match, then the tail is copied down one slot per cycle; list makes a
// count pass, then three priority passes, then returns to idle. Each command ends with exactly one
// beat carrying last=1.
`default_nettype none

module ordered_keyed_task_table
    import okt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire     aclk,
    input  wire     aresetn,
    input  wire     s_valid,
    output logic    s_ready,
    input  okt_in_t s_data,
    output logic    m_valid,
    input  wire     m_ready,
    output okt_out_t m_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    okt_entry_t mem [CAPACITY];

    okt_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  fill_count_reg, fill_count_next;
    logic [CNT_W-1:0]  rd_addr_reg, rd_addr_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]  eval_idx_reg, eval_idx_next;
    okt_entry_t        rd_data_reg;
    logic [2:0]        act_reg, act_next;
    logic [15:0]       key_reg, key_next;
    okt_entry_t        ent_reg, ent_next;
    logic [1:0]        stat_reg, stat_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [1:0]        pass_reg, pass_next;
    logic              m_valid_reg, m_valid_next;
    okt_out_t          m_data_reg, m_data_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    okt_entry_t        wr_entry;
    logic              advance;
    logic              can_issue;
    logic              out_free;
    logic              list_stall;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign can_issue = (rd_addr_reg < fill_count_reg);
    assign list_stall = (state_reg == ST_LIST) && rd_pend_reg &&
                        (rd_data_reg.prio == pass_reg) && !out_free;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            rd_pend_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            rd_pend_reg    <= rd_pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg  <= rd_addr_next;
        eval_idx_reg <= eval_idx_next;
        act_reg      <= act_next;
        key_reg      <= key_next;
        ent_reg      <= ent_next;
        stat_reg     <= stat_next;
        found_reg    <= found_next;
        total_reg    <= total_next;
        n_reg        <= n_next;
        pass_reg     <= pass_next;
        m_data_reg   <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        rd_addr_next    = rd_addr_reg;
        rd_pend_next    = rd_pend_reg;
        eval_idx_next   = eval_idx_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        ent_next        = ent_reg;
        stat_next       = stat_reg;
        found_next      = found_reg;
        total_next      = total_reg;
        n_next          = n_reg;
        pass_next       = pass_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        rd_idx          = rd_addr_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_idx          = eval_idx_reg;
        wr_entry        = rd_data_reg;
        advance         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next     = s_data.action;
                    key_next     = s_data.task_id;
                    rd_addr_next = '0;
                    rd_pend_next = 1'b0;
                    total_next   = '0;
                    found_next   = 1'b0;
                    stat_next    = STAT_OK;
                    state_next   = ST_RESP;
                    case (s_data.action)
                        ACT_APPEND: begin
                            if (fill_count_reg >= CNT_W'(CAPACITY)) begin
                                stat_next = STAT_FULL;
                            end else begin
                                wr_en           = 1'b1;
                                wr_idx          = fill_count_reg[IDX_W-1:0];
                                wr_entry.id     = s_data.task_id;
                                wr_entry.prio   = s_data.task_priority;
                                wr_entry.complete = 1'b0;
                                fill_count_next = fill_count_reg + CNT_W'(1);
                            end
                        end
                        ACT_REMOVE: begin
                            if (fill_count_reg == '0) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_SEARCH, ACT_MARK: begin
                            if (fill_count_reg == '0) begin
                                stat_next = STAT_NOT_FOUND;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_PEEK: begin
                            if (fill_count_reg == '0) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                rd_idx     = IDX_W'(fill_count_reg - CNT_W'(1));
                                state_next = ST_PEEK;
                            end
                        end
                        ACT_LIST: begin
                            if (fill_count_reg == '0) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                state_next = ST_COUNT;
                            end
                        end
                        default: begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                advance = 1'b1;
                if (rd_pend_reg && rd_data_reg.id == key_reg) begin
                    ent_next = rd_data_reg;
                    if (act_reg == ACT_MARK) begin
                        wr_en             = 1'b1;
                        wr_idx            = eval_idx_reg;
                        wr_entry.complete = 1'b1;
                        ent_next.complete = 1'b1;
                    end
                    if (act_reg == ACT_REMOVE) begin
                        state_next = ST_SHIFT;
                    end else begin
                        stat_next  = STAT_OK;
                        found_next = 1'b1;
                        state_next = ST_RESP;
                    end
                end else if (!rd_pend_reg && !can_issue) begin
                    stat_next  = STAT_NOT_FOUND;
                    found_next = 1'b0;
                    state_next = ST_RESP;
                end
            end

            // close the gap: entry read at i lands at i-1
            ST_SHIFT: begin
                advance = 1'b1;
                if (rd_pend_reg) begin
                    wr_en  = 1'b1;
                    wr_idx = eval_idx_reg - IDX_W'(1);
                end else if (!can_issue) begin
                    fill_count_next = fill_count_reg - CNT_W'(1);
                    stat_next       = STAT_OK;
                    found_next      = 1'b1;
                    state_next      = ST_RESP;
                end
            end

            ST_COUNT: begin
                advance = 1'b1;
                if (rd_pend_reg) begin
                    if (rd_data_reg.prio != 2'd0) begin
                        total_next = total_reg + CNT_W'(1);
                    end
                end else if (!can_issue) begin
                    if (total_reg == '0) begin
                        stat_next  = STAT_OK;
                        found_next = 1'b0;
                        state_next = ST_RESP;
                    end else begin
                        pass_next    = PRIO_FIRST;
                        n_next       = '0;
                        rd_addr_next = '0;
                        state_next   = ST_LIST;
                    end
                end
            end

            ST_LIST: begin
                if (rd_pend_reg && rd_data_reg.prio == pass_reg) begin
                    if (out_free) begin
                        advance                    = 1'b1;
                        m_valid_next               = 1'b1;
                        m_data_next.status         = STAT_OK;
                        m_data_next.found          = 1'b1;
                        m_data_next.entry_id       = rd_data_reg.id;
                        m_data_next.entry_priority = rd_data_reg.prio;
                        m_data_next.entry_complete = rd_data_reg.complete;
                        m_data_next.entry_count    = 5'(fill_count_reg);
                        m_data_next.last           = ((n_reg + CNT_W'(1)) == total_reg);
                        n_next                     = n_reg + CNT_W'(1);
                    end
                end else begin
                    advance = 1'b1;
                    if (!rd_pend_reg && !can_issue) begin
                        if (pass_reg == PRIO_LAST) begin
                            state_next = ST_IDLE;
                        end else begin
                            pass_next    = pass_reg + 2'd1;
                            rd_addr_next = '0;
                        end
                    end
                end
            end

            ST_PEEK: begin
                ent_next   = rd_data_reg;
                stat_next  = STAT_OK;
                found_next = 1'b1;
                state_next = ST_RESP;
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.status         = stat_reg;
                    m_data_next.found          = found_reg;
                    m_data_next.entry_id       = found_reg ? ent_reg.id : 16'd0;
                    m_data_next.entry_priority = found_reg ? ent_reg.prio : 2'd0;
                    m_data_next.entry_complete = found_reg && ent_reg.complete;
                    m_data_next.entry_count    = 5'(fill_count_reg);
                    m_data_next.last           = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // read pipeline: issue the next address while the previous entry is evaluated
        if (advance) begin
            rd_pend_next = can_issue;
            if (can_issue) begin
                rd_en         = 1'b1;
                rd_idx        = rd_addr_reg[IDX_W-1:0];
                eval_idx_next = rd_addr_reg[IDX_W-1:0];
                rd_addr_next  = rd_addr_reg + CNT_W'(1);
            end
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_fill_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_count_reg != $past(fill_count_reg)) |->
            ($past(state_reg) == ST_IDLE || $past(state_reg) == ST_SHIFT))
        else $error("fill count changed outside append or remove");

    a_list_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIST) |-> (n_reg <= total_reg))
        else $error("list emitted more beats than counted entries");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        list_stall |=> ($stable(rd_data_reg) && $stable(eval_idx_reg) && rd_pend_reg))
        else $error("read data lost during output stall");

endmodule

`default_nettype wire
